FILE: sv/triplet_low_complexity_filter_macros.svh
// Assertion macros for the triplet low-complexity filter.
`ifndef TRIPLET_LOW_COMPLEXITY_FILTER_MACROS_SVH
`define TRIPLET_LOW_COMPLEXITY_FILTER_MACROS_SVH

`ifndef SYNTH

// Antecedent true at an edge implies consequent at the same edge.
`define TLCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlcf: same-cycle check failed");

// Antecedent true at an edge implies consequent at the following edge.
`define TLCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlcf: next-cycle check failed");

`else

`define TLCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TLCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/tlcf_pkg.sv
// Shared types, constants and helper functions of the triplet low-complexity filter.
package tlcf_pkg;

    localparam int SYMBOL_W             = 8;
    localparam int THR_W                = 7;
    localparam int BASE_W               = 3;
    localparam int TRIPLETS             = 125;
    localparam int IDX_W                = $clog2(TRIPLETS);
    localparam int DEFAULT_MAX_READ_LEN = 64;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 7'd8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0
    } reg_idx_t;

    typedef enum logic [BASE_W-1:0] {
        BASE_A = 3'd0,
        BASE_C = 3'd1,
        BASE_G = 3'd2,
        BASE_T = 3'd3,
        BASE_N = 3'd4
    } base_t;

    typedef logic [IDX_W-1:0] idx_t;

    // Map a raw character to its base code; anything unknown is N.
    function automatic base_t base_of(input logic [SYMBOL_W-1:0] ch);
        base_t b;
        case (ch) inside
            8'h41, 8'h61:               b = BASE_A;
            8'h43, 8'h63:               b = BASE_C;
            8'h47, 8'h67:               b = BASE_G;
            8'h54, 8'h74, 8'h55, 8'h75: b = BASE_T;
            default:                    b = BASE_N;
        endcase
        return b;
    endfunction

    // Base-5 code of three bases, oldest first.
    function automatic idx_t triplet_index(input base_t d2, input base_t d1, input base_t d0);
        idx_t r;
        r = IDX_W'(d2) * IDX_W'(25) + IDX_W'(d1) * IDX_W'(5) + IDX_W'(d0);
        return r;
    endfunction

endpackage

FILE: sv/tlcf_if.sv
// Valid/ready channel interfaces: character requests in, verdict requests out.
interface tlcf_sym_if
    import tlcf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface tlcf_verdict_if;
    logic valid;
    logic ready;
    logic low_complexity;

    modport source (output valid, output low_complexity, input ready);
    modport sink   (input valid, input low_complexity, output ready);
endinterface

FILE: sv/tlcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/triplet_low_complexity_filter.sv
// Triplet low-complexity filter: streams read characters (last_symbol marking each read's
// end), maps each to a base A/C/G/T(U)/N, and counts every overlapping base triplet of
// the read in 125 per-read counters that saturate at MAX_READ_LEN. Once a counter reaches
// repeat_threshold the read is judged low-complexity and its remaining characters are not
// counted. The character flagged last_symbol produces one verdict request on verdict_out;
// other characters produce none. Reads of one or two bases never count a triplet.
// Rate: one character per cycle. A read's last character passes the counting stage, then
// the output register, to reach verdict_out. The triplet code is formed at the input
// edge and issues a read of the counter RAM; the counting stage then bumps the counter
// and writes it back. A counter written in the cycle of a following read is forwarded,
// so repeated triplets in consecutive characters never stall. Counters clear at once at
// the end of a read through a per-entry valid vector, so there is no clearing pass after
// reset and no gap between reads. The input stalls only when a verdict is waiting in the
// output register and the next character in flight is also the last of its read.
// repeat_threshold sits at APB byte address 0; write it only while the block is idle.
module triplet_low_complexity_filter
    import tlcf_pkg::*;
#(
    parameter int MAX_READ_LEN = DEFAULT_MAX_READ_LEN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tlcf_sym_if.sink              sym_in,
    tlcf_verdict_if.source        verdict_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "triplet_low_complexity_filter_macros.svh"

    localparam int CNT_W = $clog2(MAX_READ_LEN + 1);
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READ_LEN);

    // ---------------------------------------------------------------- config port
    logic [THR_W-1:0] thr_reg;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = cfg_hit ? APB_DATA_W'(thr_reg) : '0;

    // ---------------------------------------------------------------- input stage
    // The last two bases live as a short shift line of digits; the triplet code is the
    // base-5 value of those two and the current character's base.
    base_t     d0_reg, d1_reg;
    logic [1:0] bases_reg;
    base_t     base_now;
    idx_t      idx_now;
    logic      accept;
    logic      cnt_en_now;

    // Counting stage
    logic             b_valid_reg;
    logic             b_last_reg;
    logic             b_cnt_en_reg;
    idx_t             b_idx_reg;
    logic             fwd_hit_reg;
    logic [CNT_W-1:0] fwd_val_reg;
    logic             b_fire;

    logic             rejected_reg;
    logic [TRIPLETS-1:0] valid_reg;
    logic [CNT_W-1:0] ram_q;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic             ram_we;
    logic             hit;
    logic             out_free;

    // Output register
    logic out_valid_reg;
    logic out_lc_reg;

    assign base_now   = base_of(sym_in.symbol);
    assign idx_now    = triplet_index(d1_reg, d0_reg, base_now);
    assign cnt_en_now = bases_reg[1];
    assign accept     = sym_in.valid && sym_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_reg    <= BASE_A;
            d1_reg    <= BASE_A;
            bases_reg <= 2'd0;
        end
        else if (accept)
        begin
            if (sym_in.last_symbol)
            begin
                // drop the read's history ready for the next read
                d0_reg    <= BASE_A;
                d1_reg    <= BASE_A;
                bases_reg <= 2'd0;
            end
            else
            begin
                d0_reg <= base_now;
                d1_reg <= d0_reg;
                if (bases_reg != 2'd3)
                begin
                    bases_reg <= bases_reg + 2'd1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- counter RAM
    tlcf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TRIPLETS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_idx_reg),
        .wdata (new_cnt),
        .re    (accept),
        .raddr (idx_now),
        .rdata (ram_q)
    );

    // ---------------------------------------------------------------- counting stage
    assign out_free = !out_valid_reg || verdict_out.ready;
    assign b_fire   = b_valid_reg && (!b_last_reg || out_free);
    assign sym_in.ready = !b_valid_reg || b_fire;

    // Forwarded value wins, then the RAM word if the entry was written this read.
    assign cur_cnt = fwd_hit_reg ? fwd_val_reg :
                     (valid_reg[b_idx_reg] ? ram_q : '0);
    assign new_cnt = (cur_cnt < CNT_MAX) ? cur_cnt + CNT_W'(1) : cur_cnt;
    assign ram_we  = b_fire && b_cnt_en_reg && !rejected_reg;
    assign hit     = b_cnt_en_reg && !rejected_reg && (CMP_W'(new_cnt) >= CMP_W'(thr_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
            // the RAM returns the old word if the stage ahead writes the same entry now
            fwd_hit_reg <= ram_we && !b_last_reg && (b_idx_reg == idx_now);
        end
        else if (b_fire)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_last_reg   <= sym_in.last_symbol;
            b_cnt_en_reg <= cnt_en_now;
            b_idx_reg    <= idx_now;
            fwd_val_reg  <= new_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rejected_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else if (b_fire)
        begin
            if (b_last_reg)
            begin
                // clear every per-read counter at once
                rejected_reg <= 1'b0;
                valid_reg    <= '0;
            end
            else
            begin
                if (hit)
                begin
                    rejected_reg <= 1'b1;
                end
                if (ram_we)
                begin
                    valid_reg[b_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_fire && b_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_last_reg)
        begin
            out_lc_reg <= rejected_reg || hit;
        end
    end

    assign verdict_out.valid          = out_valid_reg;
    assign verdict_out.low_complexity = out_lc_reg;

    // ---------------------------------------------------------------- assertions
    `TLCF_ASSERT_SAME(a_stall_only_on_full_output, clk, rst_n, !sym_in.ready, b_valid_reg && b_last_reg && out_valid_reg && !verdict_out.ready)
    `TLCF_ASSERT_NEXT(a_read_end_clears_flag, clk, rst_n, b_fire && b_last_reg, !rejected_reg && (valid_reg == '0))
    `TLCF_ASSERT_NEXT(a_last_char_resets_history, clk, rst_n, accept && sym_in.last_symbol, bases_reg == 2'd0)
    `TLCF_ASSERT_NEXT(a_verdict_follows_last, clk, rst_n, b_fire && b_last_reg, out_valid_reg)

endmodule
